FILE: hdl/journal_revoke_table_top_assert.svh
// Assertion macros for the journal revoke table.
// Included by files that check their own control logic; needs no package.
`ifndef JOURNAL_REVOKE_TABLE_TOP_ASSERT_SVH
`define JOURNAL_REVOKE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/jrt_pkg.sv
// Shared types, codes and helpers for the journal revoke table.
// No dependencies; compiled before the interfaces and modules.
`default_nettype none

package jrt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int BLK_W  = 64;
  localparam int POS_W  = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  // Item operation codes; code 3 is unused and handled by default arms
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_ADDED = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             found;
    logic             free;
    logic [POS_W-1:0] found_pos;
  } scan_tok_t;

  // Table update broadcast to every cell
  typedef struct packed {
    logic             clear;
    logic             write;
    logic [BLK_W-1:0] blk;
    logic [POS_W-1:0] pos;
  } wr_cmd_t;

  // Circular window test between replay tail and stored position
  function automatic logic window_hit(input logic [POS_W-1:0] stored,
                                      input logic [POS_W-1:0] tail,
                                      input logic [POS_W-1:0] where);
    logic wrap;
    logic above_tail;
    logic below_pos;
    wrap       = stored < tail;
    above_tail = tail < where;
    below_pos  = where < stored;
    return wrap ? (above_tail | below_pos) : (above_tail & below_pos);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/jrt_if.sv
// Valid/ready channel interfaces for items and results.
// Depends on jrt_pkg for field widths.
`default_nettype none

interface jrt_in_if import jrt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [BLK_W-1:0] block_number;
  logic [POS_W-1:0] journal_position;

  modport source (output valid, op, block_number, journal_position, input ready);
  modport sink   (input valid, op, block_number, journal_position, output ready);
endinterface

interface jrt_out_if import jrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              revoked;

  modport source (output valid, status, revoked, input ready);
  modport sink   (input valid, status, revoked, output ready);
endinterface

`default_nettype wire

FILE: hdl/jrt_cell.sv
// One table slot: holds a block number, its journal position and a valid bit,
// and updates the search token on its way along the row. Depends on jrt_pkg.
`default_nettype none

module jrt_cell import jrt_pkg::*; #(
  parameter int IDX_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [BLK_W-1:0] key_blk,
  input  wire wr_cmd_t          wr_cmd,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire scan_tok_t        tok_in,
  input  wire logic [IDX_W-1:0] found_idx_in,
  input  wire logic [IDX_W-1:0] free_idx_in,
  output      scan_tok_t        tok_out,
  output      logic [IDX_W-1:0] found_idx_out,
  output      logic [IDX_W-1:0] free_idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             valid_r;
  logic [BLK_W-1:0] block_r;
  logic [POS_W-1:0] pos_r;
  scan_tok_t        tok_r, tok_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             hit;
  logic             sel;

  assign hit = valid_r && (block_r == key_blk);
  assign sel = wr_cmd.write && (wr_idx == MY_IDX);

  // Fold this slot into the token: first match and first free slot win
  always_comb begin
    tok_nxt        = tok_in;
    found_idx_nxt  = found_idx_in;
    free_idx_nxt   = free_idx_in;
    if (tok_in.active && !tok_in.found && hit) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.found_pos = pos_r;
      found_idx_nxt     = MY_IDX;
    end
    if (tok_in.active && !tok_in.free && !valid_r) begin
      tok_nxt.free = 1'b1;
      free_idx_nxt = MY_IDX;
    end
  end

  // Valid bit: cleared by reset or a clear beat, set when this slot is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_cmd.clear) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      valid_r <= 1'b1;
    end
  end

  // Slot contents
  always_ff @(posedge clk) begin
    if (sel) begin
      block_r <= wr_cmd.blk;
      pos_r   <= wr_cmd.pos;
    end
  end

  // Hand the token to the next cell; only the active flag needs a reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_nxt.active;
    end
    tok_r.found     <= tok_nxt.found;
    tok_r.free      <= tok_nxt.free;
    tok_r.found_pos <= tok_nxt.found_pos;
    found_idx_r     <= found_idx_nxt;
    free_idx_r      <= free_idx_nxt;
  end

  assign tok_out       = tok_r;
  assign found_idx_out = found_idx_r;
  assign free_idx_out  = free_idx_r;

endmodule

`default_nettype wire

FILE: hdl/journal_revoke_table_top.sv
// Journal revoke table: a row of TABLE_DEPTH slot cells searched by a token.
// Add and check beats pass ST_LAUNCH, ST_SCAN and ST_RESULT, the token walking
// one cell per cycle; clear and unused-op beats go straight to ST_RESULT.
// A new beat is taken only in ST_IDLE. A result waits in an output register.
// Synchronous active-low reset empties the table and sets replay_tail to zero.
`default_nettype none
`include "journal_revoke_table_top_assert.svh"

module journal_revoke_table_top import jrt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  jrt_in_if.sink                in_ch,
  jrt_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_wdata
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [BLK_W-1:0]  key_blk_r;
  logic [POS_W-1:0]  key_pos_r;
  logic [POS_W-1:0]  tail_r;
  scan_tok_t         fin_tok_r;
  logic [IDX_W-1:0]  fin_found_idx_r;
  logic [IDX_W-1:0]  fin_free_idx_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_revoked_r;

  scan_tok_t         tok       [TABLE_DEPTH+1];
  logic [IDX_W-1:0]  found_idx [TABLE_DEPTH+1];
  logic [IDX_W-1:0]  free_idx  [TABLE_DEPTH+1];

  wr_cmd_t           wr_cmd;
  logic [IDX_W-1:0]  wr_idx;
  stat_t             res_status;
  logic              res_revoked;
  logic              in_take;
  logic              load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign load        = (state_r == ST_RESULT) && (!out_valid_r || out_ch.ready);

  // Inject a fresh token into the first cell during launch
  always_comb begin
    tok[0]        = '0;
    tok[0].active = (state_r == ST_LAUNCH);
    found_idx[0]  = '0;
    free_idx[0]   = '0;
  end

  // Row of slot cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    jrt_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .key_blk       (key_blk_r),
      .wr_cmd        (wr_cmd),
      .wr_idx        (wr_idx),
      .tok_in        (tok[i]),
      .found_idx_in  (found_idx[i]),
      .free_idx_in   (free_idx[i]),
      .tok_out       (tok[i+1]),
      .found_idx_out (found_idx[i+1]),
      .free_idx_out  (free_idx[i+1])
    );
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (in_ch.op == OP_ADD || in_ch.op == OP_CHECK) begin
            state_nxt = ST_LAUNCH;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (tok[TABLE_DEPTH].active) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r      <= in_ch.op;
      key_blk_r <= in_ch.block_number;
      key_pos_r <= in_ch.journal_position;
    end
  end

  // Hold the token as it leaves the last cell
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && tok[TABLE_DEPTH].active) begin
      fin_tok_r       <= tok[TABLE_DEPTH];
      fin_found_idx_r <= found_idx[TABLE_DEPTH];
      fin_free_idx_r  <= free_idx[TABLE_DEPTH];
    end
  end

  // Replay tail register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r <= '0;
    end else if (cfg_we) begin
      tail_r <= cfg_wdata;
    end
  end

  // Decide the outcome and the table update
  always_comb begin
    res_status  = STAT_DONE;
    res_revoked = 1'b0;
    wr_cmd      = '0;
    wr_cmd.blk  = key_blk_r;
    wr_cmd.pos  = key_pos_r;
    wr_idx      = fin_found_idx_r;
    case (op_r)
      OP_ADD: begin
        if (fin_tok_r.found) begin
          wr_cmd.write = load;
        end else if (fin_tok_r.free) begin
          wr_cmd.write = load;
          wr_idx       = fin_free_idx_r;
          res_status   = STAT_ADDED;
        end else begin
          res_status   = STAT_FULL;
        end
      end
      OP_CHECK: begin
        res_revoked = fin_tok_r.found && window_hit(fin_tok_r.found_pos, tail_r, key_pos_r);
      end
      OP_CLEAR: begin
        wr_cmd.clear = load;
      end
      default: begin
        res_status = STAT_DONE;
      end
    endcase
  end

  // Output register: fill on load, drain on handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r  <= res_status;
      out_revoked_r <= res_revoked;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.revoked = out_revoked_r;

  `JRT_ASSERT_NXT(a_launch_then_scan, clk, rst_n, state_r == ST_LAUNCH,
                  state_r == ST_SCAN, "launch not followed by scan")
  `JRT_ASSERT_IMP(a_token_exit_in_scan, clk, rst_n, tok[TABLE_DEPTH].active,
                  state_r == ST_SCAN, "token left the row outside a scan")
  `JRT_ASSERT_IMP(a_no_update_on_accept, clk, rst_n, in_take,
                  !wr_cmd.write && !wr_cmd.clear, "table update while taking a beat")
  `JRT_ASSERT_IMP(a_revoked_only_on_hit, clk, rst_n, load && res_revoked,
                  op_r == OP_CHECK && fin_tok_r.found, "revoked without a check hit")

endmodule

`default_nettype wire
